### rtl/gfpm_pkg.sv
`timescale 1ns / 1ps

package gfpm_pkg;

    // default sizes of the stores
    localparam int MAX_Q_DEF   = 16;
    localparam int MAX_LEN_DEF = 16;

    localparam logic [4:0] FIELD_SIZE_RST = 5'd2;

    // request codes carried in the kind field
    localparam logic [2:0] KIND_ADD_WR  = 3'd0;
    localparam logic [2:0] KIND_MUL_WR  = 3'd1;
    localparam logic [2:0] KIND_LOAD_A  = 3'd2;
    localparam logic [2:0] KIND_LOAD_B  = 3'd3;
    localparam logic [2:0] KIND_MULT    = 3'd4;
    localparam logic [2:0] KIND_FIND_PR = 3'd5;

    // result codes
    localparam logic RESULT_COEF = 1'b0;
    localparam logic RESULT_PRIM = 1'b1;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] table_row;
        logic [3:0] table_col;
        logic [3:0] value;
        logic [3:0] coef_index;
        logic [4:0] len_a;
        logic [4:0] len_b;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [4:0] out_index;
        logic [3:0] out_coef;
        logic       last;
        logic [3:0] primitive_res;
        logic       prim_found;
    } t_out_item;

    // true when an operand value addresses an existing row or column
    function automatic logic idx_ok(input logic [4:0] v, input int lim);
        return int'(v) < lim;
    endfunction

    // zero counts as one, counts above the store depth saturate
    function automatic int clamp_len(input logic [4:0] n, input int lim);
        int r;
        r = int'(n);
        if (r == 0) begin
            r = 1;
        end else if (r > lim) begin
            r = lim;
        end
        return r;
    endfunction

endpackage

### rtl/gfpm_ram.sv
`timescale 1ns / 1ps

module gfpm_ram #(
    parameter int AW = 4,
    parameter int DW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/table_driven_gf_poly_multiply.sv
`timescale 1ns / 1ps

// polynomial multiplier and primitive-element search over a field GF(q) that is defined
// entirely by two loaded tables, an addition table and a multiplication table, each
// indexed by [first operand][second operand]. items with kind 0..3 write a table entry
// or a coefficient of A or B and leave the block idle, so loads stream back to back.
// a multiply (kind 4) walks all la*lb coefficient pairs on one shared read-modify-write
// path: coefficient read, product-table read together with the accumulator read,
// sum-table read, accumulator write; it then emits la+lb-1 product coefficients lowest
// index first, each after an accumulator read and held while the output is stalled, the
// final one flagged with last. lengths of 0 count as 1, lengths above MAX_LEN as MAX_LEN.
// a primitive search (kind 5) steps candidates a = 2 .. q-1 and forms the powers a^e
// through the product table by check, table read and load per power; it answers with
// one item, prim_found low and primitive_res 0 when no candidate qualifies (always so
// for q below 3). field_size is to be written through the config port while the block
// is idle, which the block itself does not enforce; a value above MAX_Q acts as MAX_Q.
// table writes or loads outside the stores are dropped, and a table read at an operand
// outside the table yields 0. no store is cleared at reset: tables and coefficients
// have to be written before a multiply or search reads them. the accumulator needs no
// clearing pass since the first term of each coefficient is added to zero. o_in_ready
// is high only while no multiply or search is in progress.

module table_driven_gf_poly_multiply #(
    parameter int MAX_Q   = gfpm_pkg::MAX_Q_DEF,
    parameter int MAX_LEN = gfpm_pkg::MAX_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  gfpm_pkg::t_in_item   i_in_data,
    // result output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output gfpm_pkg::t_out_item  o_out_data,
    // field size register
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_wdata
);

    // operand index width of the tables
    localparam int QW  = $clog2(MAX_Q);
    // coefficient index, coefficient count, product index and product count widths
    localparam int LW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LCW = $clog2(MAX_LEN + 1);
    localparam int KW  = (MAX_LEN > 1) ? $clog2(2 * MAX_LEN - 1) : 1;
    localparam int NW  = $clog2(2 * MAX_LEN);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_MUL_COEF  = 11'b000_0000_0010,  // read a_i and b_j
        S_MUL_PROD  = 11'b000_0000_0100,  // read a_i*b_j and accum[i+j]
        S_MUL_SUM   = 11'b000_0000_1000,  // read product + accum
        S_MUL_WR    = 11'b000_0001_0000,  // write accum[i+j], advance i/j
        S_EMIT_RD   = 11'b000_0010_0000,  // read accum[idx]
        S_EMIT_OUT  = 11'b000_0100_0000,  // hand coefficient to output register
        S_PRIM_CHK  = 11'b000_1000_0000,  // test current power
        S_PRIM_RD   = 11'b001_0000_0000,  // read pw*a
        S_PRIM_LD   = 11'b010_0000_0000,  // take next power
        S_PRIM_OUT  = 11'b100_0000_0000   // hand answer to output register
    } t_state;

    t_state              r_state, n_state;
    logic [4:0]          r_field_size;
    logic [LW-1:0]       r_i, n_i, r_j, n_j;
    logic [LCW-1:0]      r_la, n_la, r_lb, n_lb;
    logic [NW-1:0]       r_n, n_n;
    logic [KW-1:0]       r_idx, n_idx;
    logic [4:0]          r_a, n_a, r_e, n_e, r_pw, n_pw;
    logic                r_found, n_found;
    logic                r_prod_oob, r_sum_oob;
    logic                r_out_valid, n_out_valid;
    gfpm_pkg::t_out_item r_out, n_out;

    logic                in_fire, slot_free;
    logic [4:0]          q_eff;
    logic                last_i, last_j, first_term, last_out;
    logic [KW-1:0]       k;

    // memory ports
    logic                tbl_row_ok, tbl_col_ok;
    logic                sum_we, prod_we;
    logic [2*QW-1:0]     tbl_waddr;
    logic                prod_re, sum_re;
    logic [4:0]          prod_row, prod_col, sum_row, sum_col;
    logic [2*QW-1:0]     prod_raddr, sum_raddr;
    logic [3:0]          prod_rdata, sum_rdata, prod_val, sum_val;
    logic                coef_ok, a_we, b_we, coef_re;
    logic [LW-1:0]       coef_waddr;
    logic [3:0]          a_rdata, b_rdata;
    logic                acc_we, acc_re;
    logic [KW-1:0]       acc_raddr;
    logic [3:0]          acc_rdata;

    assign in_fire   = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    // effective field size never exceeds the table
    assign q_eff = (int'(r_field_size) > MAX_Q) ? 5'(MAX_Q) : r_field_size;

    // pair walk bookkeeping
    assign last_j     = (LCW'(r_j) + LCW'(1)) == r_lb;
    assign last_i     = (LCW'(r_i) + LCW'(1)) == r_la;
    assign k          = KW'(r_i) + KW'(r_j);
    // accum[i+j] is first touched on row i = 0 or at the last column
    assign first_term = (r_i == '0) || last_j;
    assign last_out   = (NW'(r_idx) + NW'(1)) == r_n;

    // ---------------- table and coefficient stores ----------------

    assign tbl_row_ok = gfpm_pkg::idx_ok({1'b0, i_in_data.table_row}, MAX_Q);
    assign tbl_col_ok = gfpm_pkg::idx_ok({1'b0, i_in_data.table_col}, MAX_Q);
    assign tbl_waddr  = {QW'(i_in_data.table_row), QW'(i_in_data.table_col)};
    assign sum_we     = in_fire && (i_in_data.kind == gfpm_pkg::KIND_ADD_WR)
                        && tbl_row_ok && tbl_col_ok;
    assign prod_we    = in_fire && (i_in_data.kind == gfpm_pkg::KIND_MUL_WR)
                        && tbl_row_ok && tbl_col_ok;

    // product table is shared by the multiply walk and the power chain
    always_comb begin
        if (r_state == S_PRIM_RD) begin
            prod_row = r_pw;
            prod_col = r_a;
        end else begin
            prod_row = {1'b0, a_rdata};
            prod_col = {1'b0, b_rdata};
        end
    end

    assign prod_re    = (r_state == S_MUL_PROD) || (r_state == S_PRIM_RD);
    assign prod_raddr = {QW'(prod_row), QW'(prod_col)};
    assign prod_val   = r_prod_oob ? 4'd0 : prod_rdata;

    // first term of a coefficient adds to zero
    assign sum_row   = {1'b0, prod_val};
    assign sum_col   = first_term ? 5'd0 : {1'b0, acc_rdata};
    assign sum_re    = (r_state == S_MUL_SUM);
    assign sum_raddr = {QW'(sum_row), QW'(sum_col)};
    assign sum_val   = r_sum_oob ? 4'd0 : sum_rdata;

    assign coef_ok    = gfpm_pkg::idx_ok({1'b0, i_in_data.coef_index}, MAX_LEN);
    assign coef_waddr = LW'(i_in_data.coef_index);
    assign a_we       = in_fire && (i_in_data.kind == gfpm_pkg::KIND_LOAD_A) && coef_ok;
    assign b_we       = in_fire && (i_in_data.kind == gfpm_pkg::KIND_LOAD_B) && coef_ok;
    assign coef_re    = (r_state == S_MUL_COEF);

    assign acc_we    = (r_state == S_MUL_WR);
    assign acc_re    = (r_state == S_MUL_PROD) || (r_state == S_EMIT_RD);
    assign acc_raddr = (r_state == S_EMIT_RD) ? r_idx : k;

    gfpm_ram #(.AW(2 * QW), .DW(4)) u_sum_tbl (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_in_data.value),
        .i_re    (sum_re),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    gfpm_ram #(.AW(2 * QW), .DW(4)) u_prod_tbl (
        .i_clk   (i_clk),
        .i_we    (prod_we),
        .i_waddr (tbl_waddr),
        .i_wdata (i_in_data.value),
        .i_re    (prod_re),
        .i_raddr (prod_raddr),
        .o_rdata (prod_rdata)
    );

    gfpm_ram #(.AW(LW), .DW(4)) u_poly_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_in_data.value),
        .i_re    (coef_re),
        .i_raddr (r_i),
        .o_rdata (a_rdata)
    );

    gfpm_ram #(.AW(LW), .DW(4)) u_poly_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (coef_waddr),
        .i_wdata (i_in_data.value),
        .i_re    (coef_re),
        .i_raddr (r_j),
        .o_rdata (b_rdata)
    );

    gfpm_ram #(.AW(KW), .DW(4)) u_accum (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (k),
        .i_wdata (sum_val),
        .i_re    (acc_re),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    // ---------------- sequencer ----------------

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_la        = r_la;
        n_lb        = r_lb;
        n_n         = r_n;
        n_idx       = r_idx;
        n_a         = r_a;
        n_e         = r_e;
        n_pw        = r_pw;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in_data.kind)
                        gfpm_pkg::KIND_MULT: begin
                            n_la    = LCW'(gfpm_pkg::clamp_len(i_in_data.len_a, MAX_LEN));
                            n_lb    = LCW'(gfpm_pkg::clamp_len(i_in_data.len_b, MAX_LEN));
                            n_n     = NW'(n_la) + NW'(n_lb) - NW'(1);
                            n_i     = '0;
                            n_j     = '0;
                            n_state = S_MUL_COEF;
                        end
                        gfpm_pkg::KIND_FIND_PR: begin
                            // no candidate below q = 3
                            if (q_eff < 5'd3) begin
                                n_found = 1'b0;
                                n_a     = 5'd0;
                                n_state = S_PRIM_OUT;
                            end else begin
                                n_a     = 5'd2;
                                n_pw    = 5'd2;
                                n_e     = 5'd1;
                                n_state = S_PRIM_CHK;
                            end
                        end
                        default: begin
                            // table writes and loads go straight to the stores
                        end
                    endcase
                end
            end
            S_MUL_COEF: n_state = S_MUL_PROD;
            S_MUL_PROD: n_state = S_MUL_SUM;
            S_MUL_SUM:  n_state = S_MUL_WR;
            S_MUL_WR: begin
                if (last_j) begin
                    n_j = '0;
                    if (last_i) begin
                        n_idx   = '0;
                        n_state = S_EMIT_RD;
                    end else begin
                        n_i     = r_i + LW'(1);
                        n_state = S_MUL_COEF;
                    end
                end else begin
                    n_j     = r_j + LW'(1);
                    n_state = S_MUL_COEF;
                end
            end
            S_EMIT_RD: n_state = S_EMIT_OUT;
            S_EMIT_OUT: begin
                if (slot_free) begin
                    n_out_valid         = 1'b1;
                    n_out.result_kind   = gfpm_pkg::RESULT_COEF;
                    n_out.out_index     = 5'(r_idx);
                    n_out.out_coef      = acc_rdata;
                    n_out.last          = last_out;
                    n_out.primitive_res = 4'd0;
                    n_out.prim_found    = 1'b0;
                    if (last_out) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + KW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_PRIM_CHK: begin
                if (r_pw == 5'd1) begin
                    // power hit one early: try the next candidate, or answer not found when none is left
                    if ((r_a + 5'd1) < q_eff) begin
                        n_a     = r_a + 5'd1;
                        n_pw    = r_a + 5'd1;
                        n_e     = 5'd1;
                        n_state = S_PRIM_CHK;
                    end else begin
                        n_found = 1'b0;
                        n_a     = 5'd0;
                        n_state = S_PRIM_OUT;
                    end
                end else if (({1'b0, r_e} + 6'd2) >= {1'b0, q_eff}) begin
                    // powers 1 .. q-2 all differ from one
                    n_found = 1'b1;
                    n_state = S_PRIM_OUT;
                end else begin
                    n_e     = r_e + 5'd1;
                    n_state = S_PRIM_RD;
                end
            end
            S_PRIM_RD: n_state = S_PRIM_LD;
            S_PRIM_LD: begin
                n_pw    = {1'b0, prod_val};
                n_state = S_PRIM_CHK;
            end
            S_PRIM_OUT: begin
                if (slot_free) begin
                    n_out_valid         = 1'b1;
                    n_out.result_kind   = gfpm_pkg::RESULT_PRIM;
                    n_out.out_index     = 5'd0;
                    n_out.out_coef      = 4'd0;
                    n_out.last          = 1'b1;
                    n_out.primitive_res = r_found ? 4'(r_a) : 4'd0;
                    n_out.prim_found    = r_found;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_field_size <= gfpm_pkg::FIELD_SIZE_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_field_size <= i_cfg_wdata;
            end
        end
    end

    // counters and payload
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_la    <= n_la;
        r_lb    <= n_lb;
        r_n     <= n_n;
        r_idx   <= n_idx;
        r_a     <= n_a;
        r_e     <= n_e;
        r_pw    <= n_pw;
        r_found <= n_found;
        r_out   <= n_out;
        // out-of-table reads come back as zero
        if (prod_re) begin
            r_prod_oob <= !(gfpm_pkg::idx_ok(prod_row, MAX_Q)
                            && gfpm_pkg::idx_ok(prod_col, MAX_Q));
        end
        if (sum_re) begin
            r_sum_oob <= !(gfpm_pkg::idx_ok(sum_row, MAX_Q)
                           && gfpm_pkg::idx_ok(sum_col, MAX_Q));
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/gfpm_checker.sv
`timescale 1ns / 1ps

module gfpm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input gfpm_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input gfpm_pkg::t_out_item o_out_data
);

    logic in_fire;

    assign in_fire = i_in_valid && o_in_ready;

    // a waiting result item is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    // a waiting result item keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // loads and table writes never stall the input
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_in_data.kind == gfpm_pkg::KIND_ADD_WR
                    || i_in_data.kind == gfpm_pkg::KIND_MUL_WR
                    || i_in_data.kind == gfpm_pkg::KIND_LOAD_A
                    || i_in_data.kind == gfpm_pkg::KIND_LOAD_B)
        |=> o_in_ready)
        else $error("input stalled after a load item");

    // a multiply holds off further items while it works
    a_mult_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.kind == gfpm_pkg::KIND_MULT |=> !o_in_ready)
        else $error("input ready during multiply");

    // a search answer is a single item and carries no element when none was found
    a_prim_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == gfpm_pkg::RESULT_PRIM
        |-> o_out_data.last && (o_out_data.prim_found || o_out_data.primitive_res == 4'd0))
        else $error("malformed search answer");

endmodule

bind table_driven_gf_poly_multiply gfpm_checker u_gfpm_checker (.*);

### verif/gfpm_result_checker.sv
`timescale 1ns / 1ps

module gfpm_result_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  gfpm_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  gfpm_pkg::t_out_item i_out_data,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending
);

    // shadow copy of the field tables, coefficients and field size
    logic [3:0] sum_rows  [gfpm_pkg::MAX_Q_DEF][gfpm_pkg::MAX_Q_DEF];
    logic [3:0] prod_rows [gfpm_pkg::MAX_Q_DEF][gfpm_pkg::MAX_Q_DEF];
    logic [3:0] coefs_a   [gfpm_pkg::MAX_LEN_DEF];
    logic [3:0] coefs_b   [gfpm_pkg::MAX_LEN_DEF];
    logic [4:0] field_q;

    gfpm_pkg::t_out_item awaited_results[$];

    function automatic int coef_count(input logic [4:0] n);
        if (n == 5'd0) begin
            return 1;
        end
        if (int'(n) > gfpm_pkg::MAX_LEN_DEF) begin
            return gfpm_pkg::MAX_LEN_DEF;
        end
        return int'(n);
    endfunction

    task automatic predict_product(input logic [4:0] len_a_raw, input logic [4:0] len_b_raw);
        int                  la;
        int                  lb;
        int                  n;
        logic [3:0]          acc [2*gfpm_pkg::MAX_LEN_DEF-1];
        logic [3:0]          term;
        gfpm_pkg::t_out_item r;
        la = coef_count(len_a_raw);
        lb = coef_count(len_b_raw);
        n  = la + lb - 1;
        for (int k = 0; k < 2*gfpm_pkg::MAX_LEN_DEF-1; k++) begin
            acc[k] = 4'd0;
        end
        for (int i = 0; i < la; i++) begin
            for (int j = 0; j < lb; j++) begin
                term       = prod_rows[coefs_a[i]][coefs_b[j]];
                acc[i + j] = sum_rows[term][acc[i + j]];
            end
        end
        for (int k = 0; k < n; k++) begin
            r             = '0;
            r.result_kind = gfpm_pkg::RESULT_COEF;
            r.out_index   = 5'(k);
            r.out_coef    = acc[k];
            r.last        = (k == n - 1);
            awaited_results.push_back(r);
        end
    endtask

    // first candidate from 2 whose powers up to q-2 never hit one
    task automatic predict_generator();
        int                  q;
        int                  a;
        int                  e;
        logic [3:0]          pw;
        bit                  ok;
        bit                  hit;
        gfpm_pkg::t_out_item r;
        q   = (int'(field_q) > gfpm_pkg::MAX_Q_DEF) ? gfpm_pkg::MAX_Q_DEF : int'(field_q);
        hit = 1'b0;
        a   = 2;
        while (!hit && a < q) begin
            ok = 1'b1;
            pw = 4'(a);
            e  = 1;
            while (ok && e + 1 < q) begin
                if (e > 1) begin
                    pw = prod_rows[pw][4'(a)];
                end
                if (pw == 4'd1) begin
                    ok = 1'b0;
                end
                e++;
            end
            if (ok) begin
                hit = 1'b1;
            end else begin
                a++;
            end
        end
        r               = '0;
        r.result_kind   = gfpm_pkg::RESULT_PRIM;
        r.last          = 1'b1;
        r.primitive_res = hit ? 4'(a) : 4'd0;
        r.prim_found    = hit;
        awaited_results.push_back(r);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        gfpm_pkg::t_out_item want;
        if (!i_rst_n) begin
            field_q = gfpm_pkg::FIELD_SIZE_RST;
            awaited_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                field_q = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result item: kind %0d index %0d",
                           i_out_data.result_kind, i_out_data.out_index);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", want.result_kind, i_out_data.result_kind);
                    check_field("out_index", want.out_index, i_out_data.out_index);
                    check_field("out_coef", want.out_coef, i_out_data.out_coef);
                    check_field("last", want.last, i_out_data.last);
                    check_field("primitive_res", want.primitive_res,
                                i_out_data.primitive_res);
                    check_field("prim_found", want.prim_found, i_out_data.prim_found);
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.kind)
                    gfpm_pkg::KIND_ADD_WR: begin
                        sum_rows[i_in_data.table_row][i_in_data.table_col] = i_in_data.value;
                    end
                    gfpm_pkg::KIND_MUL_WR: begin
                        prod_rows[i_in_data.table_row][i_in_data.table_col] = i_in_data.value;
                    end
                    gfpm_pkg::KIND_LOAD_A: begin
                        coefs_a[i_in_data.coef_index] = i_in_data.value;
                    end
                    gfpm_pkg::KIND_LOAD_B: begin
                        coefs_b[i_in_data.coef_index] = i_in_data.value;
                    end
                    gfpm_pkg::KIND_MULT: begin
                        predict_product(i_in_data.len_a, i_in_data.len_b);
                    end
                    gfpm_pkg::KIND_FIND_PR: begin
                        predict_generator();
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

### verif/table_driven_gf_poly_multiply_tb.sv
`timescale 1ns / 1ps

module table_driven_gf_poly_multiply_tb;

    // generous bound: covers a run where every multiply is 16 by 16 and every result stalls
    localparam int CYCLE_LIMIT      = 2_000_000;
    // loads go straight to the stores, so a short pause lets the block settle before a config write
    localparam int SETTLE_CYCLES    = 8;
    localparam int RANDOM_PER_PHASE = 70;

    // kinds the block ignores
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    gfpm_pkg::t_in_item  in_data;
    logic                out_valid;
    logic                out_ready;
    gfpm_pkg::t_out_item out_data;
    logic                cfg_we;
    logic [4:0]          cfg_wdata;

    int fail_count;
    int pending;
    int cycle_count;
    bit calm;

    // run statistics for the summary
    int n_items;
    int n_mult;
    int n_search;
    int n_coef_load;
    int n_table_wr;

    table_driven_gf_poly_multiply u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    gfpm_result_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // wait between items for either side, none at all during a calm stretch
    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    // binary fields use xor and carry-less products, the others are prime fields
    function automatic logic [3:0] field_add(input int q, input int r, input int c);
        if ((q & (q - 1)) == 0) begin
            return 4'(r ^ c);
        end
        return 4'((r + c) % q);
    endfunction

    function automatic logic [3:0] field_mul(input int q, input int r, input int c);
        int p;
        int poly;
        int k;
        if ((q & (q - 1)) != 0) begin
            return 4'((r * c) % q);
        end
        k    = (q == 4) ? 2 : (q == 8) ? 3 : 4;
        poly = (q == 4) ? 'h7 : (q == 8) ? 'hB : 'h13;
        p    = 0;
        for (int b = 0; b < 4; b++) begin
            if (((c >> b) & 1) != 0) begin
                p = p ^ (r << b);
            end
        end
        // reduce modulo the field polynomial, highest degree first
        for (int b = 6; b >= k; b--) begin
            if (((p >> b) & 1) != 0) begin
                p = p ^ (poly << (b - k));
            end
        end
        return 4'(p);
    endfunction

    // fields that the kind ignores get random bits
    function automatic gfpm_pkg::t_in_item random_item(input logic [2:0] kind);
        logic [31:0]        bits;
        gfpm_pkg::t_in_item it;
        bits    = $urandom;
        it      = bits[$bits(gfpm_pkg::t_in_item)-1:0];
        it.kind = kind;
        return it;
    endfunction

    // offers one item, valid held with a steady payload until taken
    task automatic push(input gfpm_pkg::t_in_item it);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
        n_items++;
        case (it.kind)
            gfpm_pkg::KIND_ADD_WR, gfpm_pkg::KIND_MUL_WR: n_table_wr++;
            gfpm_pkg::KIND_LOAD_A, gfpm_pkg::KIND_LOAD_B: n_coef_load++;
            gfpm_pkg::KIND_MULT:                          n_mult++;
            gfpm_pkg::KIND_FIND_PR:                       n_search++;
            default: begin
            end
        endcase
    endtask

    task automatic table_write(input logic [2:0] kind, input int r, input int c,
                               input logic [3:0] v);
        gfpm_pkg::t_in_item it;
        it           = random_item(kind);
        it.table_row = 4'(r);
        it.table_col = 4'(c);
        it.value     = v;
        push(it);
    endtask

    task automatic coef_load(input logic [2:0] kind, input int idx, input logic [3:0] v);
        gfpm_pkg::t_in_item it;
        it            = random_item(kind);
        it.coef_index = 4'(idx);
        it.value      = v;
        push(it);
    endtask

    task automatic multiply(input int la, input int lb);
        gfpm_pkg::t_in_item it;
        it       = random_item(gfpm_pkg::KIND_MULT);
        it.len_a = 5'(la);
        it.len_b = 5'(lb);
        push(it);
    endtask

    // sender holds off until every expected result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_field_size(input logic [4:0] v);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // both tables over the q by q square of a real field
    task automatic load_field(input int q);
        for (int r = 0; r < q; r++) begin
            for (int c = 0; c < q; c++) begin
                table_write(gfpm_pkg::KIND_ADD_WR, r, c, field_add(q, r, c));
                table_write(gfpm_pkg::KIND_MUL_WR, r, c, field_mul(q, r, c));
            end
        end
    endtask

    // result side: random stall per item, released on calm stretches
    initial begin
        int stall;
        out_ready <= 1'b0;
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
        end
    end

    initial begin
        int                 phase_q [3];
        int                 qe;
        int                 pick;
        int                 la;
        int                 lb;
        gfpm_pkg::t_in_item it;

        // fields grow phase by phase, so every value stays inside a written square
        phase_q     = '{3, 5, 8};
        calm        = 1'b0;
        i_rst_n     <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        @(posedge i_clk);

        // ignored kinds, one with every bit set
        push(random_item(KIND_SPARE_LO));
        it = '1;
        push(it);

        // q below 3 has no candidate, nothing is read from the tables
        push(random_item(gfpm_pkg::KIND_FIND_PR));
        set_field_size(5'd0);
        push(random_item(gfpm_pkg::KIND_FIND_PR));
        set_field_size(5'd1);
        push(random_item(gfpm_pkg::KIND_FIND_PR));

        // q of 4 where both candidates square to one: no element found
        set_field_size(5'd4);
        table_write(gfpm_pkg::KIND_MUL_WR, 2, 2, 4'd1);
        table_write(gfpm_pkg::KIND_MUL_WR, 3, 3, 4'd1);
        push(random_item(gfpm_pkg::KIND_FIND_PR));

        // random phases, each on its own field with freshly loaded tables
        foreach (phase_q[p]) begin
            set_field_size(5'(phase_q[p]));
            qe = phase_q[p];
            load_field(qe);
            if (p == 0) begin
                // every coefficient slot written before the first multiply reads it
                for (int i = 0; i < gfpm_pkg::MAX_LEN_DEF; i++) begin
                    coef_load(gfpm_pkg::KIND_LOAD_A, i, 4'($urandom_range(0, qe - 1)));
                    coef_load(gfpm_pkg::KIND_LOAD_B, i, 4'($urandom_range(0, qe - 1)));
                end
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (i % 20 == 0) begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    // coefficients inside the field
                    coef_load((pick < 35) ? gfpm_pkg::KIND_LOAD_A : gfpm_pkg::KIND_LOAD_B,
                              $urandom_range(0, 15), 4'($urandom_range(0, qe - 1)));
                end else if (pick < 78) begin
                    // small polynomials most of the time, any length now and then
                    if ($urandom_range(0, 4) != 0) begin
                        la = $urandom_range(1, 4);
                        lb = $urandom_range(1, 4);
                    end else begin
                        la = $urandom_range(0, 31);
                        lb = $urandom_range(0, 31);
                    end
                    multiply(la, lb);
                end else if (pick < 88) begin
                    push(random_item(gfpm_pkg::KIND_FIND_PR));
                end else if (pick < 95) begin
                    // noise: a stray entry inside the loaded square of either table
                    table_write(($urandom_range(0, 1) == 0) ? gfpm_pkg::KIND_ADD_WR
                                                            : gfpm_pkg::KIND_MUL_WR,
                                $urandom_range(0, qe - 1), $urandom_range(0, qe - 1),
                                4'($urandom_range(0, qe - 1)));
                end else begin
                    push(random_item(($urandom_range(0, 1) == 0) ? KIND_SPARE_LO
                                                                 : KIND_SPARE_HI));
                end
                if ($urandom_range(0, 39) == 0) begin
                    drain_results();
                end
            end
        end

        // zero lengths count as one, lengths above 16 saturate
        calm = 1'b0;
        push(random_item(gfpm_pkg::KIND_FIND_PR));
        multiply(0, 0);
        multiply(31, 31);
        multiply(16, 1);
        multiply(1, 16);
        multiply(17, 2);

        // powers of 2 in GF(16) need only column 2 of the product table
        drain_results();
        for (int r = 0; r < gfpm_pkg::MAX_Q_DEF; r++) begin
            table_write(gfpm_pkg::KIND_MUL_WR, r, 2, field_mul(16, r, 2));
        end
        set_field_size(5'd16);
        push(random_item(gfpm_pkg::KIND_FIND_PR));
        // a field size above the table acts as 16
        set_field_size(5'd31);
        push(random_item(gfpm_pkg::KIND_FIND_PR));

        drain_results();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d items: %0d multiplies, %0d primitive searches,",
                 n_items, n_mult, n_search);
        $display("  %0d coef loads, %0d table writes; field sizes 0, 1, 2, 4, 16, 31 and 3, 5, 8",
                 n_coef_load, n_table_wr);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
rtl/gfpm_pkg.sv
rtl/gfpm_ram.sv
rtl/table_driven_gf_poly_multiply.sv
rtl/gfpm_checker.sv
verif/gfpm_result_checker.sv
verif/table_driven_gf_poly_multiply_tb.sv
